@@ rtl/core/tabulated_site_pair_force_core_macros.svh @@
// Assertion macros used by the checker file.
`ifndef TABULATED_SITE_PAIR_FORCE_CORE_MACROS_SVH
`define TABULATED_SITE_PAIR_FORCE_CORE_MACROS_SVH

// Same-cycle implication, held off during reset.
`define TSPF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tspf assertion failed");

// Next-cycle implication, held off during reset.
`define TSPF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tspf assertion failed");

`endif

@@ rtl/core/tspf_pkg.sv @@
package tspf_pkg;

  localparam int SQ_W    = 41;
  localparam int ROOT_W  = 21;
  localparam int REM_W   = ROOT_W + 2;
  localparam int INV_W   = 32;
  localparam int POS_W   = 60;
  localparam int VAL_W   = 32;
  localparam int SUM_W   = 48;
  localparam int CFG_W   = 41;
  localparam int CFG_IDX_W = 1;

  localparam logic [1:0] OP_PAIR  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SQUARED_RANGE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP      = 1'd1;

  localparam logic [SQ_W-1:0]  RANGE_RESET = 41'd274877906944;
  localparam logic [INV_W-1:0] INV_RESET   = 32'd134217728;
  localparam logic [SQ_W-1:0]  MIN_RESET   = 41'd1099511627776;

  typedef struct packed {
    logic [1:0]              site_pair;
    logic signed [VAL_W-1:0] force_x;
    logic signed [VAL_W-1:0] force_y;
    logic signed [VAL_W-1:0] force_z;
    logic signed [VAL_W-1:0] energy_term;
    logic signed [SUM_W-1:0] energy_total;
    logic [SQ_W-1:0]         closest_squared;
    logic                    last;
  } res_t;

  typedef struct packed {
    logic       load;
    logic       tbl_wr;
    logic       clear;
    logic       sep;
    logic       sum;
    logic       upd_min;
    logic       root_start;
    logic       idx_mul;
    logic       rd;
    logic       fmul;
    logic       fin;
    logic       take;
    logic       push;
    logic       flush;
    logic [1:0] pair;
  } dp_cmd_t;

  typedef struct packed {
    logic in_range;
    logic root_done;
    logic pend_vld;
    logic out_free;
  } dp_sts_t;

endpackage

@@ rtl/core/tspf_in_if.sv @@
interface tspf_in_if;
  import tspf_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [1:0]              operation;
  logic [POS_W-1:0]        first_center_xyz;
  logic [POS_W-1:0]        first_patch_xyz;
  logic [POS_W-1:0]        second_center_xyz;
  logic [POS_W-1:0]        second_patch_xyz;
  logic [2:0]              table_select;
  logic [9:0]              table_index;
  logic signed [VAL_W-1:0] table_value;

  modport source (output valid, operation, first_center_xyz, first_patch_xyz,
                  second_center_xyz, second_patch_xyz, table_select, table_index,
                  table_value, input ready);
  modport sink (input valid, operation, first_center_xyz, first_patch_xyz,
                second_center_xyz, second_patch_xyz, table_select, table_index,
                table_value, output ready);
endinterface

@@ rtl/core/tspf_out_if.sv @@
interface tspf_out_if;
  import tspf_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [1:0]              site_pair;
  logic signed [VAL_W-1:0] force_x;
  logic signed [VAL_W-1:0] force_y;
  logic signed [VAL_W-1:0] force_z;
  logic signed [VAL_W-1:0] energy_term;
  logic signed [SUM_W-1:0] energy_total;
  logic [SQ_W-1:0]         closest_squared;
  logic                    last;

  modport source (output valid, site_pair, force_x, force_y, force_z, energy_term,
                  energy_total, closest_squared, last, input ready);
  modport sink (input valid, site_pair, force_x, force_y, force_z, energy_term,
                energy_total, closest_squared, last, output ready);
endinterface

@@ rtl/core/tspf_ram.sv @@
module tspf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 3072
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/tspf_ctrl.sv @@
module tspf_ctrl
  import tspf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] operation_i,
  output logic       in_ready_o,
  input  dp_sts_t    sts_i,
  output dp_cmd_t    cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SEP  = 4'd1;
  localparam logic [3:0] S_SUM  = 4'd2;
  localparam logic [3:0] S_CHK  = 4'd3;
  localparam logic [3:0] S_ROOT = 4'd4;
  localparam logic [3:0] S_IDX  = 4'd5;
  localparam logic [3:0] S_ADDR = 4'd6;
  localparam logic [3:0] S_RD   = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;
  localparam logic [3:0] S_PUSH = 4'd9;
  localparam logic [3:0] S_NEXT = 4'd10;
  localparam logic [3:0] S_END  = 4'd11;

  logic [3:0] st_q, st_d;
  logic [1:0] pair_q, pair_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      pair_q <= 2'd0;
    end else begin
      st_q   <= st_d;
      pair_q <= pair_d;
    end
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.pair = pair_q;
    in_ready_o = 1'b0;
    st_d       = st_q;
    pair_d     = pair_q;
    case (st_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (operation_i)
            OP_PAIR: begin
              cmd_o.load = 1'b1;
              pair_d     = 2'd0;
              st_d       = S_SEP;
            end
            OP_WRITE: cmd_o.tbl_wr = 1'b1;
            OP_CLEAR: cmd_o.clear = 1'b1;
            default: ;
          endcase
        end
      end
      S_SEP: begin
        cmd_o.sep = 1'b1;
        st_d      = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        st_d      = S_CHK;
      end
      S_CHK: begin
        cmd_o.upd_min = (pair_q == 2'd0);
        if (sts_i.in_range) begin
          cmd_o.root_start = 1'b1;
          st_d             = S_ROOT;
        end else if (pair_q == 2'd0) begin
          st_d = S_IDLE;
        end else begin
          st_d = S_NEXT;
        end
      end
      S_ROOT: begin
        if (sts_i.root_done) begin
          st_d = S_IDX;
        end
      end
      S_IDX: begin
        cmd_o.idx_mul = 1'b1;
        st_d          = S_ADDR;
      end
      S_ADDR: begin
        cmd_o.rd = 1'b1;
        st_d     = S_RD;
      end
      S_RD: begin
        cmd_o.fmul = 1'b1;
        st_d       = S_FIN;
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        st_d      = S_PUSH;
      end
      S_PUSH: begin
        if (!sts_i.pend_vld) begin
          cmd_o.take = 1'b1;
          st_d       = S_NEXT;
        end else if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          st_d       = S_NEXT;
        end
      end
      S_NEXT: begin
        if (pair_q == 2'd3) begin
          st_d = S_END;
        end else begin
          pair_d = pair_q + 2'd1;
          st_d   = S_SEP;
        end
      end
      S_END: begin
        if (!sts_i.pend_vld) begin
          st_d = S_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.flush = 1'b1;
          st_d        = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

endmodule

@@ rtl/core/tspf_datapath.sv @@
module tspf_datapath
  import tspf_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  parameter int COORD_BITS  = 20
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  input  logic [POS_W-1:0]        first_center_i,
  input  logic [POS_W-1:0]        first_patch_i,
  input  logic [POS_W-1:0]        second_center_i,
  input  logic [POS_W-1:0]        second_patch_i,
  input  logic [2:0]              table_select_i,
  input  logic [9:0]              table_index_i,
  input  logic signed [VAL_W-1:0] table_value_i,
  input  dp_cmd_t                 cmd_i,
  output dp_sts_t                 sts_o,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output res_t                    res_o
);

  localparam int CB     = COORD_BITS;
  localparam int PW     = (3 * CB > POS_W) ? 3 * CB : POS_W;
  localparam int DSQ_W  = 2 * CB - 1;
  localparam int SSUM_W = 2 * CB + 1;
  localparam int LSH    = (2 * CB <= 40) ? 40 - 2 * CB : 0;
  localparam int RSH    = (2 * CB > 40) ? 2 * CB - 40 : 0;
  localparam int WW     = SSUM_W + LSH;
  localparam int PROD_W = ROOT_W + INV_W;
  localparam int IDXR_W = PROD_W - 36;
  localparam int DEPTH  = 3 * TABLE_DEPTH;
  localparam int AW     = $clog2(DEPTH);
  localparam int FP_W   = VAL_W + CB;
  localparam logic signed [FP_W-1:0] FMAX = FP_W'(32'h7fffffff);
  localparam logic signed [FP_W-1:0] FMIN = ~FMAX;

  // configuration and running state
  logic [SQ_W-1:0]  range_q;
  logic [INV_W-1:0] inv_q;
  logic [SQ_W-1:0]  min_q;
  logic signed [SUM_W-1:0] sum_q;

  // pair payload
  logic [PW-1:0]          fc_q, fp_pos_q, sc_q, sp_q;
  logic signed [CB-1:0]   sep_q [3];
  logic [DSQ_W-1:0]       dsq_q [3];
  logic [SQ_W-1:0]        sq_q;
  logic [PROD_W-1:0]      prod_q;
  logic signed [FP_W-1:0] fprod_q [3];
  logic signed [VAL_W-1:0] e_q;
  res_t new_q, pend_q, out_q;
  res_t fl_res;
  logic pend_vld_q, out_vld_q;

  // root unit
  logic [2*ROOT_W-1:0] rv_q;
  logic [REM_W-1:0]    rem_q;
  logic [ROOT_W-1:0]   root_q;
  logic [4:0]          rcnt_q;

  // site selection for the current pair
  logic [PW-1:0] pos_a, pos_b;
  logic [1:0]    bank;
  assign pos_a = cmd_i.pair[1] ? fp_pos_q : fc_q;
  assign pos_b = cmd_i.pair[0] ? sp_q : sc_q;
  assign bank  = (cmd_i.pair == 2'd0) ? 2'd0 : ((cmd_i.pair == 2'd3) ? 2'd2 : 2'd1);

  logic signed [CB-1:0]   dif [3];
  logic signed [2*CB-1:0] dsq [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dif[k] = pos_a[k*CB +: CB] - pos_b[k*CB +: CB];
      dsq[k] = dif[k] * dif[k];
    end
  end

  logic [SSUM_W-1:0] ssum;
  logic [WW-1:0]     swide;
  assign ssum  = SSUM_W'(dsq_q[0]) + SSUM_W'(dsq_q[1]) + SSUM_W'(dsq_q[2]);
  assign swide = (WW'(ssum) << LSH) >> RSH;

  // one result bit per step
  logic [REM_W-1:0] rem_sh, trial;
  assign rem_sh = {rem_q[REM_W-3:0], rv_q[2*ROOT_W-1 -: 2]};
  assign trial  = {root_q, 2'b01};

  // table index, saturated to the end of the bank
  logic [IDXR_W-1:0] idx_raw;
  logic [AW-1:0]     idx_sat, rd_addr, wr_addr;
  logic              wr_ok;
  assign idx_raw = prod_q[PROD_W-1:36];
  assign idx_sat = (32'(idx_raw) > 32'(TABLE_DEPTH - 1)) ? AW'(TABLE_DEPTH - 1) : AW'(idx_raw);
  assign rd_addr = AW'(bank) * AW'(TABLE_DEPTH) + idx_sat;
  assign wr_addr = AW'(table_select_i[2:1]) * AW'(TABLE_DEPTH) + AW'(table_index_i);
  assign wr_ok   = cmd_i.tbl_wr && (table_select_i < 3'd6)
                   && (32'(table_index_i) < 32'(TABLE_DEPTH));

  logic [VAL_W-1:0] e_rd, f_rd;

  tspf_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_energy (
    .clk_i  (clk_i),
    .we_i   (wr_ok && !table_select_i[0]),
    .waddr_i(wr_addr),
    .wdata_i(table_value_i),
    .re_i   (cmd_i.rd),
    .raddr_i(rd_addr),
    .rdata_o(e_rd)
  );

  tspf_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_force (
    .clk_i  (clk_i),
    .we_i   (wr_ok && table_select_i[0]),
    .waddr_i(wr_addr),
    .wdata_i(table_value_i),
    .re_i   (cmd_i.rd),
    .raddr_i(rd_addr),
    .rdata_o(f_rd)
  );

  function automatic logic signed [VAL_W-1:0] sat_force(input logic signed [FP_W-1:0] p);
    logic signed [FP_W-1:0] s;
    s = p >>> (CB - 1);
    if (s > FMAX) begin
      return VAL_W'(FMAX);
    end else if (s < FMIN) begin
      return VAL_W'(FMIN);
    end
    return VAL_W'(s);
  endfunction

  logic signed [SUM_W:0]   sum_ext;
  logic signed [SUM_W-1:0] sum_new;
  assign sum_ext = {sum_q[SUM_W-1], sum_q} + (SUM_W+1)'(e_q);
  always_comb begin
    if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
      sum_new = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_new = sum_ext[SUM_W-1:0];
    end
  end

  // held result marked as the final one of the pair
  always_comb begin
    fl_res      = pend_q;
    fl_res.last = 1'b1;
  end

  // control and running state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q    <= RANGE_RESET;
      inv_q      <= INV_RESET;
      min_q      <= MIN_RESET;
      sum_q      <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      rcnt_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_SQUARED_RANGE: range_q <= cfg_data_i;
          CFG_INV_STEP:      inv_q   <= cfg_data_i[INV_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.clear) begin
        min_q <= MIN_RESET;
        sum_q <= '0;
      end
      if (cmd_i.upd_min && (sq_q < min_q)) begin
        min_q <= sq_q;
      end
      if (cmd_i.fin) begin
        sum_q <= sum_new;
      end
      if (cmd_i.take) begin
        pend_vld_q <= 1'b1;
      end else if (cmd_i.flush) begin
        pend_vld_q <= 1'b0;
      end
      if (cmd_i.push || cmd_i.flush) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      if (cmd_i.root_start) begin
        rcnt_q <= 5'(ROOT_W);
      end else if (rcnt_q != '0) begin
        rcnt_q <= rcnt_q - 5'd1;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      fc_q     <= PW'(first_center_i);
      fp_pos_q <= PW'(first_patch_i);
      sc_q     <= PW'(second_center_i);
      sp_q     <= PW'(second_patch_i);
    end
    if (cmd_i.sep) begin
      for (int k = 0; k < 3; k++) begin
        sep_q[k] <= dif[k];
        dsq_q[k] <= dsq[k][DSQ_W-1:0];
      end
    end
    if (cmd_i.sum) begin
      sq_q <= SQ_W'(swide);
    end
    if (cmd_i.root_start) begin
      rv_q   <= (2*ROOT_W)'(sq_q);
      rem_q  <= '0;
      root_q <= '0;
    end else if (rcnt_q != '0) begin
      rv_q <= rv_q << 2;
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
    if (cmd_i.idx_mul) begin
      prod_q <= PROD_W'(root_q) * PROD_W'(inv_q);
    end
    if (cmd_i.fmul) begin
      e_q <= e_rd;
      for (int k = 0; k < 3; k++) begin
        fprod_q[k] <= FP_W'($signed(f_rd)) * FP_W'(sep_q[k]);
      end
    end
    if (cmd_i.fin) begin
      new_q.site_pair       <= cmd_i.pair;
      new_q.force_x         <= sat_force(fprod_q[0]);
      new_q.force_y         <= sat_force(fprod_q[1]);
      new_q.force_z         <= sat_force(fprod_q[2]);
      new_q.energy_term     <= e_q;
      new_q.energy_total    <= sum_new;
      new_q.closest_squared <= min_q;
      new_q.last            <= 1'b0;
    end
    if (cmd_i.take || cmd_i.push) begin
      pend_q <= new_q;
    end
    if (cmd_i.push) begin
      out_q <= pend_q;
    end else if (cmd_i.flush) begin
      out_q <= fl_res;
    end
  end

  assign sts_o.in_range  = (sq_q < range_q);
  assign sts_o.root_done = (rcnt_q == '0);
  assign sts_o.pend_vld  = pend_vld_q;
  assign sts_o.out_free  = !out_vld_q || out_ready_i;
  assign out_valid_o     = out_vld_q;
  assign res_o           = out_q;

endmodule

@@ rtl/core/tabulated_site_pair_force_core.sv @@
// Tabulated site-pair force engine for two rigid center-plus-patch particles.
// Input channel (in_ch): one item per operation. A compute item carries four
// site positions; a table write stores one energy or force entry; a clear
// resets the energy sum and the running minimum. Writes and clears finish in
// the accepting cycle and produce no result.
// Output channel (out_ch): one item per site pair inside the cutoff, in the
// order center-center, center-patch, patch-center, patch-patch; last marks
// the final one. A pair whose centers lie outside the cutoff yields nothing.
// Sequence: every site pair inside the cutoff passes the 21-step square root
// unit that all four pairs share, followed by one multiply for the index,
// one table read and one force multiply; a pair outside the cutoff skips
// the root and the lookup. One compute item is worked on at a time.
// One result is held back until the next is known, so that last is right.
// A stalled receiver holds the output register; the engine waits while a
// result must move into that full register and resumes when it drains.
// Reset: cutoff, table step, energy sum and minimum take their reset values;
// table contents are undefined until written.
module tabulated_site_pair_force_core
  import tspf_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  parameter int COORD_BITS  = 20
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  tspf_in_if.sink              in_ch,
  tspf_out_if.source           out_ch,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  res_t    res;

  // sequence each site pair through the shared datapath
  tspf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .operation_i(in_ch.operation),
    .in_ready_o (in_ch.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // separations, root, lookup, force products and result staging
  tspf_datapath #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .first_center_i (in_ch.first_center_xyz),
    .first_patch_i  (in_ch.first_patch_xyz),
    .second_center_i(in_ch.second_center_xyz),
    .second_patch_i (in_ch.second_patch_xyz),
    .table_select_i (in_ch.table_select),
    .table_index_i  (in_ch.table_index),
    .table_value_i  (in_ch.table_value),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (out_ch.ready),
    .out_valid_o    (out_ch.valid),
    .res_o          (res)
  );

  // drive the result item onto the channel
  assign out_ch.site_pair       = res.site_pair;
  assign out_ch.force_x         = res.force_x;
  assign out_ch.force_y         = res.force_y;
  assign out_ch.force_z         = res.force_z;
  assign out_ch.energy_term     = res.energy_term;
  assign out_ch.energy_total    = res.energy_total;
  assign out_ch.closest_squared = res.closest_squared;
  assign out_ch.last            = res.last;

endmodule

@@ rtl/core/tspf_checker.sv @@
`include "tabulated_site_pair_force_core_macros.svh"

module tspf_checker
  import tspf_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid,
  input logic              in_ready,
  input logic [1:0]        operation,
  input logic              out_valid,
  input logic              out_ready,
  input logic [VAL_W-1:0]  force_x,
  input logic [SUM_W-1:0]  energy_total,
  input logic [SQ_W-1:0]   closest_squared,
  input logic              last
);

  `TSPF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid && $stable(force_x) && $stable(energy_total) && $stable(last))
  `TSPF_ASSERT_NEXT(a_pair_busy, clk_i, rst_ni, in_valid && in_ready && (operation == OP_PAIR), !in_ready)
  `TSPF_ASSERT_NEXT(a_clear_quick, clk_i, rst_ni, in_valid && in_ready && (operation == OP_CLEAR), in_ready)
  `TSPF_ASSERT_NOW(a_min_bound, clk_i, rst_ni, out_valid, closest_squared <= MIN_RESET)

endmodule

bind tabulated_site_pair_force_core tspf_checker u_tspf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .operation      (in_ch.operation),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .force_x        (out_ch.force_x),
  .energy_total   (out_ch.energy_total),
  .closest_squared(out_ch.closest_squared),
  .last           (out_ch.last)
);

@@ sim/tabulated_site_pair_force_core_tb.sv @@
`timescale 1ns / 100ps

module tabulated_site_pair_force_core_tb;
  import tspf_pkg::*;

  localparam int DEPTH      = 1024;
  localparam int CB         = 20;
  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE     = 150;
  localparam int N_RANDOM   = 144;
  localparam int PRELOAD    = 8;     // low entries filled in every table

  typedef struct {
    logic [1:0]              op;
    logic [POS_W-1:0]        fc, fp, sc, sp;
    logic [2:0]              sel;
    logic [9:0]              idx;
    logic signed [VAL_W-1:0] val;
  } pair_item_t;

  // A directed row; where typed is set the first result's energy and
  // closest squared distance are taken from the row rather than from the predictor.
  typedef struct {
    pair_item_t              it;
    bit                      typed;
    logic signed [VAL_W-1:0] exp_energy;
    logic [SQ_W-1:0]         exp_closest;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0] cfg_data_i;

  tspf_in_if  in_ch();
  tspf_out_if out_ch();

  tabulated_site_pair_force_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Predictor state: own copy of the tables, sum, minimum and registers.
  logic signed [VAL_W-1:0] energy_tab [0:3*DEPTH-1];
  logic signed [VAL_W-1:0] force_tab  [0:3*DEPTH-1];
  longint                  sum_model;
  logic [SQ_W-1:0]         min_model;
  logic [SQ_W-1:0]         range_model;
  logic [INV_W-1:0]        inv_model;

  res_t pending_forces[$];
  int   mismatches;
  int   results_seen;
  int   items_sent;
  int   idle_cycles;
  bit   gaps_on;
  int   stall_left;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [VAL_W-1:0] scaled_force(logic signed [VAL_W-1:0] f,
                                                           longint s);
    longint p, q;
    p = longint'(f) * s;
    q = p >>> (CB - 1);   // arithmetic shift gives floor rounding
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[31:0];
  endfunction

  // Work out the results of one accepted item and update the state.
  function automatic void predict_forces(pair_item_t it, bit typed,
                                         logic signed [VAL_W-1:0] te,
                                         logic [SQ_W-1:0] tc);
    logic [POS_W-1:0] a, b;
    logic [CB-1:0] d;
    longint sep[3];
    longint unsigned sq, ix;
    int bank, addr, n;
    res_t r;
    n = 0;
    if (it.op == OP_WRITE) begin
      if (it.sel < 3'd6) begin
        addr = int'(it.sel >> 1) * DEPTH + int'(it.idx);
        if (it.sel[0]) force_tab[addr] = it.val;
        else energy_tab[addr] = it.val;
      end
      return;
    end
    if (it.op == OP_CLEAR) begin
      sum_model = 0;
      min_model = MIN_RESET;
      return;
    end
    if (it.op != OP_PAIR) return;
    for (int p = 0; p < 4; p++) begin
      a = (p < 2) ? it.fc : it.fp;
      b = (p[0] == 1'b0) ? it.sc : it.sp;
      bank = (p == 0) ? 0 : (p == 3) ? 2 : 1;
      sq = 0;
      for (int k = 0; k < 3; k++) begin
        d = a[k*CB +: CB] - b[k*CB +: CB];
        sep[k] = longint'($signed(d));
        sq += longint'(sep[k] * sep[k]);
      end
      if (p == 0 && sq < min_model) min_model = sq[SQ_W-1:0];
      if (sq >= range_model) begin
        if (p == 0) return;
        continue;
      end
      ix = (int_sqrt(sq) * longint'(inv_model)) >> 36;
      if (ix > DEPTH - 1) ix = DEPTH - 1;
      addr = bank * DEPTH + int'(ix);
      sum_model += longint'(energy_tab[addr]);
      if (sum_model > 64'sd140737488355327) sum_model = 64'sd140737488355327;
      if (sum_model < -64'sd140737488355328) sum_model = -64'sd140737488355328;
      r.site_pair       = p[1:0];
      r.force_x         = scaled_force(force_tab[addr], sep[0]);
      r.force_y         = scaled_force(force_tab[addr], sep[1]);
      r.force_z         = scaled_force(force_tab[addr], sep[2]);
      r.energy_term     = energy_tab[addr];
      r.energy_total    = sum_model[SUM_W-1:0];
      r.closest_squared = min_model;
      r.last            = 1'b0;
      if (typed && n == 0) begin
        r.energy_term     = te;
        r.closest_squared = tc;
      end
      pending_forces.push_back(r);
      n++;
    end
    if (n > 0) pending_forces[pending_forces.size() - 1].last = 1'b1;
  endfunction

  // Offer one item, optionally after an idle burst, and hold it until taken.
  task automatic send_item(pair_item_t it, bit typed = 1'b0,
                           logic signed [VAL_W-1:0] te = '0,
                           logic [SQ_W-1:0] tc = '0);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_ch.valid             <= 1'b1;
    in_ch.operation         <= it.op;
    in_ch.first_center_xyz  <= it.fc;
    in_ch.first_patch_xyz   <= it.fp;
    in_ch.second_center_xyz <= it.sc;
    in_ch.second_patch_xyz  <= it.sp;
    in_ch.table_select      <= it.sel;
    in_ch.table_index       <= it.idx;
    in_ch.table_value       <= it.val;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_forces(it, typed, te, tc);
    items_sent++;
  endtask

  // Drop valid, drain every expected result, then let the engine go quiet.
  task automatic drain;
    in_ch.valid <= 1'b0;
    while (pending_forces.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] ix, logic [CFG_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= ix;
    cfg_data_i  <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (ix == CFG_SQUARED_RANGE) range_model = v;
    else inv_model = v[INV_W-1:0];
  endtask

  function automatic pair_item_t make_item(logic [1:0] op, logic [POS_W-1:0] fc,
                                           logic [POS_W-1:0] fp, logic [POS_W-1:0] sc,
                                           logic [POS_W-1:0] sp, logic [2:0] sel,
                                           logic [9:0] idx, logic signed [VAL_W-1:0] val);
    pair_item_t it;
    it.op = op; it.fc = fc; it.fp = fp; it.sc = sc; it.sp = sp;
    it.sel = sel; it.idx = idx; it.val = val;
    return it;
  endfunction

  // Place a site near another: each axis shifted by up to +/-2^k, wrapping.
  function automatic logic [POS_W-1:0] near_site(logic [POS_W-1:0] c);
    logic [POS_W-1:0] r;
    int k;
    k = $urandom_range(0, 19);
    for (int a = 0; a < 3; a++)
      r[a*CB +: CB] = c[a*CB +: CB] + CB'($urandom_range(0, 2 << k)) - CB'(1 << k);
    return r;
  endfunction

  function automatic pair_item_t random_item;
    pair_item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    it.fc  = POS_W'({$urandom, $urandom});
    it.fp  = near_site(it.fc);
    it.sc  = ($urandom_range(0, 4) == 0) ? POS_W'({$urandom, $urandom}) : near_site(it.fc);
    it.sp  = ($urandom_range(0, 4) == 0) ? POS_W'({$urandom, $urandom}) : near_site(it.sc);
    it.sel = 3'($urandom_range(0, 7));
    it.idx = 10'($urandom);
    it.val = VAL_W'($urandom);
    if (pick < 72) it.op = OP_PAIR;
    else if (pick < 90) it.op = OP_WRITE;
    else if (pick < 95) it.op = OP_CLEAR;
    else it.op = 2'd3;
    return it;
  endfunction

  // Accept-side bookkeeping and result checking.
  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (pending_forces.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result pair=%0d energy=%0d", $time,
                   out_ch.site_pair, out_ch.energy_term);
        end else begin
          e = pending_forces.pop_front();
          if (out_ch.site_pair !== e.site_pair || out_ch.force_x !== e.force_x ||
              out_ch.force_y !== e.force_y || out_ch.force_z !== e.force_z ||
              out_ch.energy_term !== e.energy_term ||
              out_ch.energy_total !== e.energy_total ||
              out_ch.closest_squared !== e.closest_squared || out_ch.last !== e.last) begin
            mismatches++;
            $display("%0t: expected pair=%0d f=(%0d,%0d,%0d) e=%0d sum=%0d min=%0d last=%0b",
                     $time, e.site_pair, e.force_x, e.force_y, e.force_z, e.energy_term,
                     e.energy_total, e.closest_squared, e.last);
            $display("%0t: actual   pair=%0d f=(%0d,%0d,%0d) e=%0d sum=%0d min=%0d last=%0b",
                     $time, out_ch.site_pair, out_ch.force_x, out_ch.force_y,
                     out_ch.force_z, out_ch.energy_term, out_ch.energy_total,
                     out_ch.closest_squared, out_ch.last);
          end
        end
      end
    end
  end

  // Receiver: stall in random bursts while gaps are on.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (gaps_on && $urandom_range(0, 4) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 3);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  initial begin
    row_t rows[$];
    row_t rw;
    logic [POS_W-1:0] zero_pos, half_x, unit_x;
    zero_pos = '0;
    half_x   = POS_W'(20'h80000);
    unit_x   = POS_W'(1);
    mismatches   = 0;
    results_seen = 0;
    items_sent   = 0;
    idle_cycles  = 0;
    gaps_on      = 1'b0;
    sum_model    = 0;
    min_model    = MIN_RESET;
    range_model  = RANGE_RESET;
    inv_model    = INV_RESET;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    in_ch.valid <= 1'b0;
    in_ch.operation <= OP_CLEAR;
    in_ch.first_center_xyz  <= '0;
    in_ch.first_patch_xyz   <= '0;
    in_ch.second_center_xyz <= '0;
    in_ch.second_patch_xyz  <= '0;
    in_ch.table_select <= '0;
    in_ch.table_index  <= '0;
    in_ch.table_value  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill the low entries of every table; the register settings below keep
    // every lookup among them, so no lookup meets an unwritten entry.
    for (int s = 0; s < 6; s++)
      for (int i = 0; i < PRELOAD; i++)
        send_item(make_item(OP_WRITE, '0, '0, '0, '0, 3'(s), 10'(i), $urandom));

    // Directed part: extremes of the values, bad writes, the unused
    // operation, a centre pair outside the cutoff and the minimum after clear.
    gaps_on = 1'b1;
    rw.typed = 1'b0; rw.exp_energy = '0; rw.exp_closest = '0;
    rw.it = make_item(OP_WRITE, '0, '0, '0, '0, 3'd0, 10'd0, 32'sd100);        rows.push_back(rw);
    rw.it = make_item(OP_WRITE, '0, '0, '0, '0, 3'd1, 10'd0, 32'sd4096);       rows.push_back(rw);
    rw.it = make_item(OP_WRITE, '0, '0, '0, '0, 3'd2, 10'd0, -32'sd5);         rows.push_back(rw);
    rw.it = make_item(OP_WRITE, '0, '0, '0, '0, 3'd4, 10'd0, 32'h7fffffff);    rows.push_back(rw);
    rw.it = make_item(OP_WRITE, '0, '0, '0, '0, 3'd5, 10'd0, 32'h80000000);    rows.push_back(rw);
    rw.it = make_item(OP_WRITE, '0, '0, '0, '0, 3'd5, 10'd1023, 32'h7fffffff); rows.push_back(rw);
    // Bad selects: ignored, so the entries above stay.
    rw.it = make_item(OP_WRITE, '0, '0, '0, '0, 3'd6, 10'd0, 32'sd1);          rows.push_back(rw);
    rw.it = make_item(OP_WRITE, '0, '0, '0, '0, 3'd7, 10'd1023, 32'h80000000); rows.push_back(rw);
    rw.it = make_item(2'd3, '1, '1, '0, '0, 3'd7, 10'd1023, 32'hffffffff);     rows.push_back(rw);
    rw.typed = 1'b1; rw.exp_energy = 32'sd100; rw.exp_closest = '0;
    rw.it = make_item(OP_PAIR, zero_pos, zero_pos, zero_pos, zero_pos, '0, '0, '0);
    rows.push_back(rw);
    rw.typed = 1'b0;
    rw.it = make_item(OP_PAIR, '1, '1, '0, '0, '0, '0, '0);                    rows.push_back(rw);
    rw.it = make_item(OP_PAIR, '1, '0, '0, '1, '0, '0, '0);                    rows.push_back(rw);
    rw.it = make_item(OP_CLEAR, '0, '0, '0, '0, '0, '0, '0);                   rows.push_back(rw);
    // Centres exactly at the cutoff: minimum moves, nothing comes out.
    rw.it = make_item(OP_PAIR, half_x, zero_pos, zero_pos, zero_pos, '0, '0, '0);
    rows.push_back(rw);
    rw.typed = 1'b1; rw.exp_energy = 32'sd100; rw.exp_closest = 41'd1;
    rw.it = make_item(OP_PAIR, unit_x, zero_pos, zero_pos, zero_pos, '0, '0, '0);
    rows.push_back(rw);
    rw.typed = 1'b0;
    rw.it = make_item(OP_PAIR, {3{20'h7ffff}}, {3{20'h80000}}, '0, '0, '0, '0, '0);
    rows.push_back(rw);
    rw.it = make_item(OP_PAIR, '0, {3{20'h80001}}, {3{20'h80000}}, '0, '0, '0, '0);
    rows.push_back(rw);
    foreach (rows[i]) send_item(rows[i].it, rows[i].typed, rows[i].exp_energy,
                                rows[i].exp_closest);
    drain();

    // Random part over several register settings, extremes among them.
    // Each step keeps the table index within the preloaded entries.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_SQUARED_RANGE, '0);
          write_reg(CFG_INV_STEP, 41'd327680);
        end
        1: begin
          write_reg(CFG_SQUARED_RANGE, 41'd1099511627776);
          write_reg(CFG_INV_STEP, 41'd524287);
        end
        2: begin
          write_reg(CFG_SQUARED_RANGE, 41'd68719476736);
          write_reg(CFG_INV_STEP, '0);
        end
        default: begin
          write_reg(CFG_SQUARED_RANGE, RANGE_RESET);
          write_reg(CFG_INV_STEP, 41'd1000000);
        end
      endcase
      for (int n = 0; n < N_RANDOM / 4; n++) begin
        // Run the tail of the last setting at full rate.
        if (ph == 3 && n >= N_RANDOM / 8) gaps_on = 1'b0;
        send_item(random_item());
      end
      drain();
    end

    $display("ran %0d items (%0d table preload writes) through 4 register settings,",
             items_sent, 6 * PRELOAD);
    $display("checked %0d force results, %0d mismatching", results_seen, mismatches);
    if (mismatches == 0 && pending_forces.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
